/* hdl/cal_pkg.sv */
// ----------------------------------------------------------------------------
// cal_pkg
// Shared types and default sizes for the cursor array list unit.
// ----------------------------------------------------------------------------
package cal_pkg;

  localparam int unsigned MaxItemsDefault  = 16;
  localparam int unsigned ItemWidthDefault = 8;

  localparam int unsigned FuncWidth = 4;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_INSERT   = 4'd0,
    FUNC_REMOVE   = 4'd1,
    FUNC_REPLACE  = 4'd2,
    FUNC_CLEAR    = 4'd3,
    FUNC_BEGIN    = 4'd4,
    FUNC_END      = 4'd5,
    FUNC_NEXT     = 4'd6,
    FUNC_PRIOR    = 4'd7,
    FUNC_MOVE_NTH = 4'd8,
    FUNC_FIND     = 4'd9,
    FUNC_READ     = 4'd10
  } func_e;

endpackage

/* hdl/cursor_array_list_unit.sv */
// ----------------------------------------------------------------------------
// cursor_array_list_unit
// Packed list of items in a RAM with a cursor; one request per transfer.
// ----------------------------------------------------------------------------
// Requests without a walk pass through the fetch, load and hold states to the
// result register. Insert, remove and find walk the RAM one entry a cycle
// through its single read port before the fetch state.
// Ready returns once the result is loaded; a new request is taken only then.
// Reset clears count and cursor (cursor -1); RAM slots at or above the count
// never reach a result, so reset and clear take no sweep of the RAM.
module cursor_array_list_unit #(
  parameter int unsigned MAX_ITEMS  = cal_pkg::MaxItemsDefault,
  parameter int unsigned ITEM_WIDTH = cal_pkg::ItemWidthDefault,
  localparam int unsigned AW    = $clog2(MAX_ITEMS),
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1),
  localparam int unsigned CUR_W = AW + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [cal_pkg::FuncWidth-1:0] func_i,
  input  logic [ITEM_WIDTH-1:0] item_value_i,
  input  logic [AW-1:0]         position_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  ok_o,
  output logic [ITEM_WIDTH-1:0] cursor_item_o,
  output logic signed [CUR_W-1:0] cursor_pos_o,
  output logic [CNT_W-1:0]      count_o,
  output logic                  is_empty_o,
  output logic                  is_full_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SHIFT = 6'b000010,
    S_SCAN  = 6'b000100,
    S_FETCH = 6'b001000,
    S_LOAD  = 6'b010000,
    S_HOLD  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  cal_pkg::func_e      func_q, func_d;
  logic [ITEM_WIDTH-1:0] val_q, val_d;
  logic [CUR_W-1:0]    cursor_q, cursor_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [AW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]       prev_ptr_q, prev_ptr_d;
  logic                reading_q, reading_d;
  logic                pend_q, pend_d;
  logic                op_ok_q, op_ok_d;

  logic                  out_valid_q, out_valid_d;
  logic                  ok_out_q, ok_out_d;
  logic [ITEM_WIDTH-1:0] item_out_q, item_out_d;
  logic [CUR_W-1:0]      pos_out_q, pos_out_d;
  logic [CNT_W-1:0]      cnt_out_q, cnt_out_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [ITEM_WIDTH-1:0] ram_wdata, ram_rdata;

  // signed views one bit wider than the cursor
  logic signed [CUR_W:0] cur_s, cnt_s, cnt_m1_s;
  logic [AW-1:0]         cur_addr, cur_next_addr, last_addr;
  logic                  on_item, at_last;

  assign cur_s         = $signed({cursor_q[CUR_W-1], cursor_q});
  assign cnt_s         = $signed({{(CUR_W + 1 - CNT_W){1'b0}}, count_q});
  assign cnt_m1_s      = cnt_s - (CUR_W + 1)'(1);
  assign cur_addr      = cursor_q[AW-1:0];
  assign cur_next_addr = cur_addr + AW'(1);
  assign last_addr     = cnt_m1_s[AW-1:0];
  assign on_item       = !cursor_q[CUR_W-1] && (count_q != '0);
  assign at_last       = (cur_s == cnt_m1_s);

  cal_ram #(
    .Width (ITEM_WIDTH),
    .Depth (MAX_ITEMS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    val_d       = val_q;
    cursor_d    = cursor_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    prev_ptr_d  = prev_ptr_q;
    reading_d   = reading_q;
    pend_d      = pend_q;
    op_ok_d     = op_ok_q;
    out_valid_d = out_valid_q;
    ok_out_d    = ok_out_q;
    item_out_d  = item_out_q;
    pos_out_d   = pos_out_q;
    cnt_out_d   = cnt_out_q;

    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = val_q;
    ram_raddr = cur_addr;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d    = cal_pkg::func_e'(func_i);
          val_d     = item_value_i;
          op_ok_d   = 1'b0;
          pend_d    = 1'b0;
          reading_d = 1'b0;
          state_d   = S_FETCH;
          case (cal_pkg::func_e'(func_i))
            cal_pkg::FUNC_INSERT: begin
              if (count_q < CNT_W'(MAX_ITEMS)) begin
                op_ok_d   = 1'b1;
                reading_d = (cnt_m1_s > cur_s);
                rd_ptr_d  = last_addr;
                state_d   = S_SHIFT;
              end
            end
            cal_pkg::FUNC_REMOVE: begin
              if (on_item) begin
                op_ok_d = 1'b1;
                if (at_last) begin
                  // removing the tail item wraps the cursor to the head (before-first if it was the only item)
                  cursor_d = (count_q == CNT_W'(1)) ? '1 : '0;
                  count_d  = count_q - CNT_W'(1);
                end else begin
                  reading_d = 1'b1;
                  rd_ptr_d  = cur_next_addr;
                  state_d   = S_SHIFT;
                end
              end
            end
            cal_pkg::FUNC_REPLACE: begin
              if (on_item) begin
                op_ok_d   = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = item_value_i;
              end
            end
            cal_pkg::FUNC_CLEAR: begin
              op_ok_d  = 1'b1;
              count_d  = '0;
              cursor_d = '1;
            end
            cal_pkg::FUNC_BEGIN: begin
              if (count_q != '0) begin
                op_ok_d  = 1'b1;
                cursor_d = '0;
              end
            end
            cal_pkg::FUNC_END: begin
              if ((count_q != '0) && !at_last) begin
                op_ok_d  = 1'b1;
                cursor_d = cnt_m1_s[CUR_W-1:0];
              end
            end
            cal_pkg::FUNC_NEXT: begin
              if ((count_q != '0) && !at_last) begin
                op_ok_d  = 1'b1;
                cursor_d = cursor_q + CUR_W'(1);
              end
            end
            cal_pkg::FUNC_PRIOR: begin
              if (on_item) begin
                op_ok_d  = 1'b1;
                cursor_d = cursor_q - CUR_W'(1);
              end
            end
            cal_pkg::FUNC_MOVE_NTH: begin
              if (CNT_W'(position_i) < count_q) begin
                op_ok_d  = 1'b1;
                cursor_d = {{(CUR_W - AW){1'b0}}, position_i};
              end
            end
            cal_pkg::FUNC_FIND: begin
              // cursor is always below count when on an item
              reading_d = (count_q != '0);
              rd_ptr_d  = cursor_q[CUR_W-1] ? '0 : cur_addr;
              state_d   = S_SCAN;
            end
            cal_pkg::FUNC_READ: begin
              op_ok_d = on_item;
            end
            default: begin
              op_ok_d = 1'b0;
            end
          endcase
        end
      end

      S_SHIFT: begin
        ram_raddr  = rd_ptr_q;
        pend_d     = reading_q;
        prev_ptr_d = rd_ptr_q;
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          ram_waddr = (func_q == cal_pkg::FUNC_INSERT) ? prev_ptr_q + AW'(1)
                                                       : prev_ptr_q - AW'(1);
        end
        if (reading_q) begin
          if (func_q == cal_pkg::FUNC_INSERT) begin
            reading_d = (rd_ptr_q != cur_next_addr);
            rd_ptr_d  = rd_ptr_q - AW'(1);
          end else begin
            reading_d = (rd_ptr_q != last_addr);
            rd_ptr_d  = rd_ptr_q + AW'(1);
          end
        end
        if (!reading_q && !pend_q) begin
          state_d = S_FETCH;
          if (func_q == cal_pkg::FUNC_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = cur_next_addr;
            ram_wdata = val_q;
            cursor_d  = cursor_q + CUR_W'(1);
            count_d   = count_q + CNT_W'(1);
          end else begin
            count_d = count_q - CNT_W'(1);
          end
        end
      end

      S_SCAN: begin
        ram_raddr  = rd_ptr_q;
        pend_d     = reading_q;
        prev_ptr_d = rd_ptr_q;
        if (reading_q) begin
          reading_d = (rd_ptr_q != last_addr);
          rd_ptr_d  = rd_ptr_q + AW'(1);
        end
        if (pend_q && (ram_rdata == val_q)) begin
          op_ok_d   = 1'b1;
          cursor_d  = {{(CUR_W - AW){1'b0}}, prev_ptr_q};
          reading_d = 1'b0;
          pend_d    = 1'b0;
          state_d   = S_FETCH;
        end else if (!reading_q && !pend_q) begin
          op_ok_d  = 1'b0;
          cursor_d = cnt_m1_s[CUR_W-1:0];
          state_d  = S_FETCH;
        end
      end

      S_FETCH: begin
        state_d = S_LOAD;
      end

      S_LOAD: begin
        state_d = S_HOLD;
      end

      S_HOLD: begin
        // wait for the result register to drain
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ok_out_d    = op_ok_q;
          item_out_d  = cursor_q[CUR_W-1] ? '0 : ram_rdata;
          pos_out_d   = cursor_q;
          cnt_out_d   = count_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= cal_pkg::FUNC_READ;
      cursor_q    <= '1;
      count_q     <= '0;
      reading_q   <= 1'b0;
      pend_q      <= 1'b0;
      op_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      cursor_q    <= cursor_d;
      count_q     <= count_d;
      reading_q   <= reading_d;
      pend_q      <= pend_d;
      op_ok_q     <= op_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    rd_ptr_q   <= rd_ptr_d;
    prev_ptr_q <= prev_ptr_d;
    ok_out_q   <= ok_out_d;
    item_out_q <= item_out_d;
    pos_out_q  <= pos_out_d;
    cnt_out_q  <= cnt_out_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_out_q;
  assign cursor_item_o = item_out_q;
  assign cursor_pos_o  = $signed(pos_out_q);
  assign count_o       = cnt_out_q;
  assign is_empty_o    = (cnt_out_q == '0);
  assign is_full_o     = (cnt_out_q == CNT_W'(MAX_ITEMS));

  // cursor never points past the last held item
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cursor_q[CUR_W-1] |-> (cur_s < cnt_s))
    else $error("cursor beyond item count");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ITEMS))
    else $error("item count above capacity");

  a_no_item_before_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (cursor_pos_o == '1)) |-> (cursor_item_o == '0))
    else $error("item reported with cursor before first");

  // a walk only starts from an accepted request
  a_walk_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SHIFT || state_q == S_SCAN) && $past(state_q == S_IDLE))
      |-> $past(in_valid_i))
    else $error("walk started without a request");

  a_ram_write_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q == S_SHIFT)) |-> ({1'b0, ram_waddr} <= cnt_s[AW:0]))
    else $error("shift wrote beyond the list end");

endmodule

/* hdl/cal_ram.sv */
// ----------------------------------------------------------------------------
// cal_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cal_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks cursor_array_list_unit against its own list-with-cursor predictor.
// Directed requests cover the empty, cursor-before-first, last-item and full
// cases. Random request mixes then run under three idling patterns, with a
// long receiver stall and one pause that drains every pending result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MaxItems   = cal_pkg::MaxItemsDefault;
  localparam int unsigned ItemW      = cal_pkg::ItemWidthDefault;
  localparam int unsigned FuncW      = cal_pkg::FuncWidth;
  localparam int unsigned PosW       = $clog2(MaxItems);
  localparam int unsigned CurW       = PosW + 1;
  localparam int unsigned CntW       = $clog2(MaxItems + 1);
  localparam int          HoldCycles = 300;
  localparam int          DrainWait  = MaxItems + 10;

  localparam logic [FuncW-1:0] FuncUnusedLo = FuncW'(cal_pkg::FUNC_READ + 1);
  localparam logic [FuncW-1:0] FuncUnusedHi = '1;

  typedef struct packed {
    logic                   ok;
    logic [ItemW-1:0]       item;
    logic signed [CurW-1:0] pos;
    logic [CntW-1:0]        count;
    logic                   empty;
    logic                   full;
  } list_status_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [FuncW-1:0]       func_i = '0;
  logic [ItemW-1:0]       item_value_i = '0;
  logic [PosW-1:0]        position_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   ok_o;
  logic [ItemW-1:0]       cursor_item_o;
  logic signed [CurW-1:0] cursor_pos_o;
  logic [CntW-1:0]        count_o;
  logic                   is_empty_o;
  logic                   is_full_o;

  cursor_array_list_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .item_value_i  (item_value_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ok_o          (ok_o),
    .cursor_item_o (cursor_item_o),
    .cursor_pos_o  (cursor_pos_o),
    .count_o       (count_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

  // predicted list contents
  logic [ItemW-1:0] list_items [MaxItems] = '{default: '0};
  int               list_len   = 0;
  int               cursor_idx = -1;

  list_status_t expected_status [$];
  int           error_count   = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;

  // receiver stall requests: a bump of stall_seq starts a long stall
  int stall_seq  = 0;
  int stall_seen = 0;
  int stall_left = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk_i) begin
    if (stall_seq != stall_seen) begin
      stall_seen  <= stall_seq;
      stall_left  <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic list_status_t apply_request(logic [FuncW-1:0] func,
                                                 logic [ItemW-1:0] value,
                                                 logic [PosW-1:0] pos);
    list_status_t r;
    int           i;
    bit           found;
    bit           on_item;
    on_item = cursor_idx >= 0 && list_len > 0;
    r.ok = 1'b0;
    case (func)
      cal_pkg::FUNC_INSERT: begin
        if (list_len < MaxItems) begin
          for (i = list_len - 1; i > cursor_idx; i--) list_items[i+1] = list_items[i];
          cursor_idx++;
          list_items[cursor_idx] = value;
          list_len++;
          r.ok = 1'b1;
        end
      end
      cal_pkg::FUNC_REMOVE: begin
        if (on_item) begin
          // taking out the last item wraps the cursor to the front (before-first if it was the only item)
          if (cursor_idx == list_len - 1) begin
            cursor_idx = (list_len == 1) ? -1 : 0;
          end else begin
            for (i = cursor_idx; i < list_len - 1; i++) list_items[i] = list_items[i+1];
          end
          list_len--;
          list_items[list_len] = '0;
          r.ok = 1'b1;
        end
      end
      cal_pkg::FUNC_REPLACE: begin
        if (on_item) begin
          list_items[cursor_idx] = value;
          r.ok = 1'b1;
        end
      end
      cal_pkg::FUNC_CLEAR: begin
        list_items = '{default: '0};
        list_len   = 0;
        cursor_idx = -1;
        r.ok       = 1'b1;
      end
      cal_pkg::FUNC_BEGIN: begin
        if (list_len > 0) begin
          cursor_idx = 0;
          r.ok = 1'b1;
        end
      end
      cal_pkg::FUNC_END, cal_pkg::FUNC_NEXT: begin
        if (list_len > 0 && cursor_idx != list_len - 1) begin
          cursor_idx = (func == cal_pkg::FUNC_END) ? list_len - 1 : cursor_idx + 1;
          r.ok = 1'b1;
        end
      end
      cal_pkg::FUNC_PRIOR: begin
        if (on_item) begin
          cursor_idx--;
          r.ok = 1'b1;
        end
      end
      cal_pkg::FUNC_MOVE_NTH: begin
        if (int'(pos) < list_len) begin
          cursor_idx = pos;
          r.ok = 1'b1;
        end
      end
      cal_pkg::FUNC_FIND: begin
        i = (cursor_idx < 0) ? 0 : cursor_idx;
        found = 1'b0;
        while (!found && i < list_len) begin
          if (list_items[i] == value) found = 1'b1;
          else i++;
        end
        cursor_idx = found ? i : list_len - 1;
        r.ok = found;
      end
      cal_pkg::FUNC_READ: r.ok = on_item;
      default: r.ok = 1'b0;
    endcase
    r.item  = (cursor_idx >= 0) ? list_items[cursor_idx] : '0;
    r.pos   = CurW'(cursor_idx);
    r.count = CntW'(list_len);
    r.empty = (list_len == 0);
    r.full  = (list_len == MaxItems);
    return r;
  endfunction

  // ready is sampled at the falling edge, where it holds its value for the next rising edge
  task automatic send_request(input logic [FuncW-1:0] func,
                              input logic [ItemW-1:0] value,
                              input logic [PosW-1:0] pos);
    bit taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= func;
    item_value_i <= value;
    position_i   <= pos;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
    expected_status.push_back(apply_request(func, value, pos));
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    list_status_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_status.size() == 0) begin
        $error("result transfer with no request pending");
        error_count++;
      end else begin
        e = expected_status.pop_front();
        if (ok_o !== e.ok) begin
          $error("ok: expected %0d, got %0d", e.ok, ok_o);
          error_count++;
        end
        if (cursor_item_o !== e.item) begin
          $error("cursor_item: expected %0h, got %0h", e.item, cursor_item_o);
          error_count++;
        end
        if (cursor_pos_o !== e.pos) begin
          $error("cursor_pos: expected %0d, got %0d", e.pos, cursor_pos_o);
          error_count++;
        end
        if (count_o !== e.count) begin
          $error("count: expected %0d, got %0d", e.count, count_o);
          error_count++;
        end
        if (is_empty_o !== e.empty) begin
          $error("is_empty: expected %0d, got %0d", e.empty, is_empty_o);
          error_count++;
        end
        if (is_full_o !== e.full) begin
          $error("is_full: expected %0d, got %0d", e.full, is_full_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed();
    // empty list, cursor before the first item
    send_request(cal_pkg::FUNC_READ, '0, '0);
    send_request(cal_pkg::FUNC_REMOVE, '0, '0);
    send_request(cal_pkg::FUNC_REPLACE, 8'hAA, '0);
    send_request(cal_pkg::FUNC_BEGIN, '0, '0);
    send_request(cal_pkg::FUNC_END, '0, '0);
    send_request(cal_pkg::FUNC_NEXT, '0, '0);
    send_request(cal_pkg::FUNC_PRIOR, '0, '0);
    send_request(cal_pkg::FUNC_FIND, 8'h00, '0);
    send_request(cal_pkg::FUNC_MOVE_NTH, '0, '0);
    send_request(FuncUnusedLo, 8'hFF, '1);
    send_request(FuncUnusedHi, 8'h00, '0);
    send_request(cal_pkg::FUNC_INSERT, 8'h00, '0);
    send_request(cal_pkg::FUNC_INSERT, 8'hFF, '0);
    send_request(cal_pkg::FUNC_INSERT, 8'h5A, '0);
    send_request(cal_pkg::FUNC_NEXT, '0, '0);
    send_request(cal_pkg::FUNC_END, '0, '0);
    // prior walks off the front to the before-first position
    send_request(cal_pkg::FUNC_MOVE_NTH, '0, '0);
    send_request(cal_pkg::FUNC_PRIOR, '0, '0);
    send_request(cal_pkg::FUNC_PRIOR, '0, '0);
    send_request(cal_pkg::FUNC_READ, '0, '0);
    send_request(cal_pkg::FUNC_FIND, 8'h5A, '0);
    send_request(cal_pkg::FUNC_BEGIN, '0, '0);
    send_request(cal_pkg::FUNC_INSERT, 8'hA5, '0);
    send_request(cal_pkg::FUNC_MOVE_NTH, '0, '1);
    send_request(cal_pkg::FUNC_REMOVE, '0, '0);
    send_request(cal_pkg::FUNC_REPLACE, 8'h81, '0);
    send_request(cal_pkg::FUNC_FIND, 8'h77, '0);
    send_request(cal_pkg::FUNC_CLEAR, '0, '0);
  endtask

  // fill to capacity while the receiver is stalled, so the input backs up
  task automatic test_full_list();
    int i;
    send_idle_pct = 0;
    stall_seq <= stall_seq + 1;
    for (i = 0; i <= MaxItems; i++) send_request(cal_pkg::FUNC_INSERT, ItemW'($urandom), '0);
    send_request(cal_pkg::FUNC_MOVE_NTH, '0, PosW'(MaxItems - 1));
    send_request(cal_pkg::FUNC_READ, '0, '0);
    send_request(cal_pkg::FUNC_FIND, list_items[MaxItems-1], '0);
    send_request(cal_pkg::FUNC_BEGIN, '0, '0);
    send_request(cal_pkg::FUNC_REMOVE, '0, '0);
    send_request(cal_pkg::FUNC_INSERT, 8'h3C, '0);
    send_request(cal_pkg::FUNC_INSERT, 8'hC3, '0);
  endtask

  function automatic logic [ItemW-1:0] pick_value();
    if (list_len > 0 && $urandom_range(0, 99) < 60)
      return list_items[$urandom_range(0, list_len - 1)];
    if ($urandom_range(0, 1) == 0) return ItemW'($urandom_range(0, 7));
    return ItemW'($urandom);
  endfunction

  task automatic test_random_mix(input int n_items);
    int               k;
    int               w;
    logic [FuncW-1:0] func;
    logic [PosW-1:0]  pos;
    for (k = 0; k < n_items; k++) begin
      w = $urandom_range(0, 99);
      if (w < 24)      func = cal_pkg::FUNC_INSERT;
      else if (w < 38) func = cal_pkg::FUNC_REMOVE;
      else if (w < 44) func = cal_pkg::FUNC_REPLACE;
      else if (w < 46) func = cal_pkg::FUNC_CLEAR;
      else if (w < 51) func = cal_pkg::FUNC_BEGIN;
      else if (w < 56) func = cal_pkg::FUNC_END;
      else if (w < 63) func = cal_pkg::FUNC_NEXT;
      else if (w < 70) func = cal_pkg::FUNC_PRIOR;
      else if (w < 80) func = cal_pkg::FUNC_MOVE_NTH;
      else if (w < 91) func = cal_pkg::FUNC_FIND;
      else if (w < 97) func = cal_pkg::FUNC_READ;
      else             func = FuncUnusedLo + FuncW'($urandom_range(0, FuncUnusedHi - FuncUnusedLo));
      if (list_len > 0 && $urandom_range(0, 99) < 70) pos = PosW'($urandom_range(0, list_len - 1));
      else pos = PosW'($urandom);
      send_request(func, pick_value(), pos);
    end
  endtask

  task automatic test_drain_pause();
    test_random_mix(20);
    wait_results_drained();
    test_random_mix(20);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 20;
    recv_idle_pct = 49;
    test_directed();
    test_full_list();
    send_idle_pct = 20;
    test_random_mix(600);
    test_drain_pause();

    send_idle_pct = 49;
    recv_idle_pct = 20;
    test_random_mix(620);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(620);

    wait_results_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
